>>> hw/rtl/tfc_pkg.sv
package tfc_pkg;

    localparam int MAX_FRAME   = 2048;
    localparam int POS_W       = $clog2(MAX_FRAME + 1);
    localparam int PATTERN_LEN = 10;
    localparam int PATTERN_W   = 80;

    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;

    localparam logic [POS_W-1:0] L3_TAGGED = POS_W'(18);
    localparam logic [POS_W-1:0] L3_PLAIN  = POS_W'(14);

    localparam logic [2:0] CFG_EXPECTED_INDEX = 3'd0;
    localparam logic [2:0] CFG_EXPECTED_VLAN  = 3'd1;
    localparam logic [2:0] CFG_MIN_PAYLOAD    = 3'd2;
    localparam logic [2:0] CFG_PATTERN_WORD0  = 3'd3;
    localparam logic [2:0] CFG_PATTERN_WORD1  = 3'd4;
    localparam logic [2:0] CFG_PATTERN_WORD2  = 3'd5;

    typedef enum logic [1:0] {
        CLS_IGNORE     = 2'd0,
        CLS_MATCH      = 2'd1,
        CLS_UNEXPECTED = 2'd2
    } t_frame_class;

    typedef struct packed {
        logic [15:0] expected_index;
        logic [11:0] match_vid;
        logic [10:0] min_data_len;
        logic [31:0] pattern_word0;
        logic [31:0] pattern_word1;
        logic [15:0] pattern_word2;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] byte_position;
        logic [15:0]      index_seen;
        logic [15:0]      outer_type;
        logic [11:0]      tag_vlan_id;
        logic [15:0]      inner_type;
        logic             stripped_tag_valid;
        logic [11:0]      stripped_vlan_id;
        logic [3:0]       header_words;
        logic [7:0]       ip_protocol;
        logic             pattern_ok;
    } t_frame_fields;

    localparam t_frame_fields FIELDS_RESET = '{
        byte_position:      '0,
        index_seen:         '0,
        outer_type:         '0,
        tag_vlan_id:        '0,
        inner_type:         '0,
        stripped_tag_valid: 1'b0,
        stripped_vlan_id:   '0,
        header_words:       '0,
        ip_protocol:        '0,
        pattern_ok:         1'b1
    };

    localparam t_cfg CFG_RESET = '{
        expected_index: 16'd8009,
        match_vid:      12'd225,
        min_data_len:   11'd101,
        pattern_word0:  32'd1937006962,
        pattern_word1:  32'd1949135973,
        pattern_word2:  16'd29556
    };

endpackage

>>> hw/rtl/tfc_field_capture.sv
module tfc_field_capture import tfc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_frame_byte,
    input  logic          i_last_byte,
    input  logic [15:0]   i_aux_tag,
    input  logic          i_aux_tag_valid,
    input  t_cfg          i_cfg,
    output t_frame_fields o_fields
);

    t_frame_fields          r_f;
    t_frame_fields          n_f;
    logic [POS_W-1:0]       p;
    logic [POS_W-1:0]       l3;
    logic [POS_W-1:0]       payload_start;
    logic [POS_W-1:0]       prefix_offset;
    logic [PATTERN_W-1:0]   pattern;
    logic [7:0]             prefix_byte;

    assign p             = r_f.byte_position;
    assign l3            = (r_f.outer_type == ETH_TYPE_VLAN) ? L3_TAGGED : L3_PLAIN;
    assign payload_start = l3 + POS_W'({r_f.header_words, 2'b00}) + POS_W'(8);
    assign prefix_offset = p - payload_start;
    assign pattern       = {i_cfg.pattern_word0, i_cfg.pattern_word1, i_cfg.pattern_word2};
    assign prefix_byte   = pattern[(PATTERN_W - 8) - 8 * prefix_offset[3:0] +: 8];

    always_comb begin
        n_f = r_f;
        if (p < POS_W'(MAX_FRAME)) begin
            if (p == POS_W'(0)) begin
                n_f.stripped_tag_valid = i_aux_tag_valid;
                n_f.stripped_vlan_id   = i_aux_tag[11:0];
            end
            if (p == POS_W'(4))  n_f.index_seen[15:8]  = i_frame_byte;
            if (p == POS_W'(5))  n_f.index_seen[7:0]   = i_frame_byte;
            if (p == POS_W'(12)) n_f.outer_type[15:8]  = i_frame_byte;
            if (p == POS_W'(13)) n_f.outer_type[7:0]   = i_frame_byte;
            if (p == POS_W'(14)) n_f.tag_vlan_id[11:8] = i_frame_byte[3:0];
            if (p == POS_W'(15)) n_f.tag_vlan_id[7:0]  = i_frame_byte;
            if (p == POS_W'(16)) n_f.inner_type[15:8]  = i_frame_byte;
            if (p == POS_W'(17)) n_f.inner_type[7:0]   = i_frame_byte;
            if (p >= POS_W'(14)) begin
                if (p == l3) n_f.header_words = i_frame_byte[3:0];
                if (p == l3 + POS_W'(9)) n_f.ip_protocol = i_frame_byte;
                if ((p > l3) && (p >= payload_start)
                        && (prefix_offset < POS_W'(PATTERN_LEN))
                        && (i_frame_byte != prefix_byte)) begin
                    n_f.pattern_ok = 1'b0;
                end
            end
            n_f.byte_position = p + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f <= FIELDS_RESET;
        end else if (i_step) begin
            r_f <= i_last_byte ? FIELDS_RESET : n_f;
        end
    end

    assign o_fields = n_f;

endmodule

>>> hw/rtl/tfc_classifier.sv
module tfc_classifier import tfc_pkg::*; (
    input  t_frame_fields i_fields,
    input  t_cfg          i_cfg,
    output t_frame_class  o_class
);

    logic             qtag;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] l3;
    logic [POS_W-1:0] l3_len;
    logic [POS_W-1:0] ihl;
    logic [POS_W-1:0] udp_data_len;
    logic [11:0]      vid;

    assign qtag         = (i_fields.outer_type == ETH_TYPE_VLAN);
    assign len          = i_fields.byte_position;
    assign l3           = qtag ? L3_TAGGED : L3_PLAIN;
    assign l3_len       = len - l3;
    assign ihl          = POS_W'({i_fields.header_words, 2'b00});
    assign udp_data_len = l3_len - ihl - POS_W'(8);
    assign vid          = qtag ? i_fields.tag_vlan_id : i_fields.stripped_vlan_id;

    always_comb begin
        if (len < POS_W'(14)) begin
            o_class = CLS_IGNORE;
        end else if (i_fields.index_seen != i_cfg.expected_index) begin
            o_class = CLS_IGNORE;
        end else if (qtag && (len < POS_W'(18))) begin
            o_class = CLS_IGNORE;
        end else if (qtag && (i_fields.inner_type != ETH_TYPE_IPV4)) begin
            o_class = CLS_IGNORE;
        end else if (!qtag && !i_fields.stripped_tag_valid) begin
            o_class = CLS_IGNORE;
        end else if (!qtag && (i_fields.outer_type != ETH_TYPE_IPV4)) begin
            o_class = CLS_IGNORE;
        end else if (vid != i_cfg.match_vid) begin
            o_class = CLS_IGNORE;
        end else if (l3_len < POS_W'(28)) begin
            o_class = CLS_UNEXPECTED;
        end else if ((ihl < POS_W'(20)) || (ihl + POS_W'(8) > l3_len)) begin
            o_class = CLS_UNEXPECTED;
        end else if (i_fields.ip_protocol != IP_PROTO_UDP) begin
            o_class = CLS_UNEXPECTED;
        end else if (udp_data_len < POS_W'(i_cfg.min_data_len)) begin
            o_class = CLS_UNEXPECTED;
        end else if (udp_data_len < POS_W'(PATTERN_LEN)) begin
            o_class = CLS_UNEXPECTED;
        end else if (!i_fields.pattern_ok) begin
            o_class = CLS_UNEXPECTED;
        end else begin
            o_class = CLS_MATCH;
        end
    end

endmodule

>>> hw/rtl/trigger_frame_classifier_unit.sv
// A frame's last byte passes the input register, then its class code is registered.
// Throughput: one frame byte per cycle; the input register is refilled while a
// finished class code waits in the output register, and only a last byte waits for it.
// Reset is synchronous and active low; it empties both registers, clears the frame
// state and loads the default configuration values.
module trigger_frame_classifier_unit import tfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_aux_tag,
    input  logic        i_aux_tag_valid,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_frame_class,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg          r_cfg;
    logic          r_in_valid;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [15:0]   r_tag;
    logic          r_tag_valid;
    logic          r_out_valid;
    t_frame_class  r_class;
    t_frame_class  n_class;
    t_frame_fields fields;
    logic          out_free;
    logic          advance;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!r_last || out_free);
    assign o_ready  = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXPECTED_INDEX: r_cfg.expected_index <= i_cfg_data[15:0];
                CFG_EXPECTED_VLAN:  r_cfg.match_vid      <= i_cfg_data[11:0];
                CFG_MIN_PAYLOAD:    r_cfg.min_data_len   <= i_cfg_data[10:0];
                CFG_PATTERN_WORD0:  r_cfg.pattern_word0  <= i_cfg_data;
                CFG_PATTERN_WORD1:  r_cfg.pattern_word1  <= i_cfg_data;
                CFG_PATTERN_WORD2:  r_cfg.pattern_word2  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte      <= i_frame_byte;
            r_last      <= i_last_byte;
            r_tag       <= i_aux_tag;
            r_tag_valid <= i_aux_tag_valid;
        end
    end

    tfc_field_capture u_capture (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_frame_byte    (r_byte),
        .i_last_byte     (r_last),
        .i_aux_tag       (r_tag),
        .i_aux_tag_valid (r_tag_valid),
        .i_cfg           (r_cfg),
        .o_fields        (fields)
    );

    tfc_classifier u_classifier (
        .i_fields (fields),
        .i_cfg    (r_cfg),
        .o_class  (n_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_class <= n_class;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_class = r_class;

endmodule
